/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at the rising edge, skipped while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: lbl");

// Implication form: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

/* hw/rtl/pcsb_pkg.sv */
// Package of the scan binner: sizes, codes, command and status types, CORDIC table.
`timescale 1ns / 1ps
`default_nettype none
package pcsb_pkg;

    localparam int NUM_BINS     = 512;
    localparam int ADDR_W       = $clog2(NUM_BINS);
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 17;
    localparam int SQRT_STEPS   = 20;
    localparam int CORD_CYC     = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;
    localparam int ROOT_CYC     = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
    localparam int CNT_W        = (ADDR_W > 5) ? ADDR_W : 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int BIN_SEL_W    = 9;
    localparam int RANGE_W      = 17;
    localparam logic [RANGE_W-1:0] EMPTY_RANGE = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT_LOW  = 3'd0,
        CFG_HEIGHT_HIGH = 3'd1,
        CFG_RANGE_LOW   = 3'd2,
        CFG_RANGE_HIGH  = 3'd3,
        CFG_ANGLE_START = 3'd4,
        CFG_ANGLE_END   = 3'd5,
        CFG_ANGLE_STEP  = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SQ,
        S_CHK,
        S_CORD,
        S_WRAP,
        S_ROOT,
        S_IDX,
        S_UPD,
        S_RDBIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        logic             acc_en;
        logic             cordic_init;
        logic             cordic_step;
        logic             div_init_d;
        logic             div_init_off;
        logic             div_step;
        logic             qd_save;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             rd_en;
        logic             rd_bin;
        logic             upd_wr;
        logic             clr_wr;
        logic             out_en;
        logic [CNT_W-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic height_ok;
        logic range_ok;
        logic off_ok;
        logic idx_ok;
    } t_dp_sts;

    // arctan(2^-i) in binary angle units, rounded
    function automatic logic [13:0] atan_tab(input logic [4:0] i);
        logic [13:0] v;
        case (i)
            5'd0:    v = 14'd8192;
            5'd1:    v = 14'd4836;
            5'd2:    v = 14'd2555;
            5'd3:    v = 14'd1297;
            5'd4:    v = 14'd651;
            5'd5:    v = 14'd326;
            5'd6:    v = 14'd163;
            5'd7:    v = 14'd81;
            5'd8:    v = 14'd41;
            5'd9:    v = 14'd20;
            5'd10:   v = 14'd10;
            5'd11:   v = 14'd5;
            5'd12:   v = 14'd3;
            5'd13:   v = 14'd1;
            5'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/pcsb_ctrl.sv */
// Controller of the scan binner: sequences clear sweep, point pipeline and bin readout.
`timescale 1ns / 1ps
`default_nettype none
module pcsb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_cmd,
    input  wire pcsb_pkg::t_dp_sts i_sts,
    output pcsb_pkg::t_dp_cmd      o_dp_cmd,
    output logic                   o_busy
);

    pcsb_pkg::t_state r_state, n_state;
    logic [pcsb_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcsb_pkg::S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcsb_pkg::S_CLEAR:
                if (r_cnt == pcsb_pkg::CNT_W'(pcsb_pkg::NUM_BINS - 1)) n_state = pcsb_pkg::S_IDLE;
            pcsb_pkg::S_IDLE:
                if (i_start) n_state = i_cmd ? pcsb_pkg::S_RDBIN : pcsb_pkg::S_SQ;
            pcsb_pkg::S_SQ:
                if (r_cnt == pcsb_pkg::CNT_W'(4)) n_state = pcsb_pkg::S_CHK;
            pcsb_pkg::S_CHK:
                n_state = (i_sts.height_ok && i_sts.range_ok) ? pcsb_pkg::S_CORD
                                                              : pcsb_pkg::S_IDLE;
            pcsb_pkg::S_CORD:
                if (r_cnt == pcsb_pkg::CNT_W'(pcsb_pkg::CORD_CYC - 1)) n_state = pcsb_pkg::S_WRAP;
            pcsb_pkg::S_WRAP:
                n_state = i_sts.off_ok ? pcsb_pkg::S_ROOT : pcsb_pkg::S_IDLE;
            pcsb_pkg::S_ROOT:
                if (r_cnt == pcsb_pkg::CNT_W'(pcsb_pkg::ROOT_CYC - 1)) n_state = pcsb_pkg::S_IDX;
            pcsb_pkg::S_IDX:
                n_state = i_sts.idx_ok ? pcsb_pkg::S_UPD : pcsb_pkg::S_IDLE;
            pcsb_pkg::S_UPD:   n_state = pcsb_pkg::S_IDLE;
            pcsb_pkg::S_RDBIN: n_state = pcsb_pkg::S_OUT;
            pcsb_pkg::S_OUT:   n_state = pcsb_pkg::S_IDLE;
            default:           n_state = pcsb_pkg::S_IDLE;
        endcase
        n_cnt = (n_state != r_state) ? '0 : r_cnt + 1'b1;
    end

    always_comb begin
        o_dp_cmd     = '0;
        o_dp_cmd.cnt = r_cnt;
        o_busy       = (r_state != pcsb_pkg::S_IDLE);
        case (r_state)
            pcsb_pkg::S_CLEAR: o_dp_cmd.clr_wr = 1'b1;
            pcsb_pkg::S_IDLE:  o_dp_cmd.load = i_start;
            pcsb_pkg::S_SQ: begin
                o_dp_cmd.mul_en = (r_cnt < pcsb_pkg::CNT_W'(4));
                o_dp_cmd.acc_en = (r_cnt != '0);
            end
            pcsb_pkg::S_CHK: begin
                o_dp_cmd.cordic_init = 1'b1;
                o_dp_cmd.div_init_d  = 1'b1;
            end
            pcsb_pkg::S_CORD: begin
                o_dp_cmd.cordic_step = (r_cnt < pcsb_pkg::CNT_W'(pcsb_pkg::CORDIC_STEPS));
                o_dp_cmd.div_step    = (r_cnt < pcsb_pkg::CNT_W'(pcsb_pkg::DIV_STEPS));
            end
            pcsb_pkg::S_WRAP: begin
                o_dp_cmd.qd_save      = 1'b1;
                o_dp_cmd.div_init_off = 1'b1;
                o_dp_cmd.sqrt_init    = 1'b1;
            end
            pcsb_pkg::S_ROOT: begin
                o_dp_cmd.div_step  = (r_cnt < pcsb_pkg::CNT_W'(pcsb_pkg::DIV_STEPS));
                o_dp_cmd.sqrt_step = (r_cnt < pcsb_pkg::CNT_W'(pcsb_pkg::SQRT_STEPS));
            end
            pcsb_pkg::S_IDX:   o_dp_cmd.rd_en = 1'b1;
            pcsb_pkg::S_UPD:   o_dp_cmd.upd_wr = 1'b1;
            pcsb_pkg::S_RDBIN: begin
                o_dp_cmd.rd_en  = 1'b1;
                o_dp_cmd.rd_bin = 1'b1;
            end
            pcsb_pkg::S_OUT:   o_dp_cmd.out_en = 1'b1;
            default:           o_dp_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/pcsb_dp.sv */
// Datapath of the scan binner: config, multiplier, CORDIC, divider, square root, bin memory.
`timescale 1ns / 1ps
`default_nettype none
module pcsb_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcsb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pcsb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic signed [19:0]                i_x_mm,
    input  wire logic signed [19:0]                i_y_mm,
    input  wire logic signed [19:0]                i_z_mm,
    input  wire logic [pcsb_pkg::BIN_SEL_W-1:0]    i_bin_select,
    input  wire pcsb_pkg::t_dp_cmd                 i_dp_cmd,
    output pcsb_pkg::t_dp_sts                      o_sts,
    output logic                                   o_valid,
    output logic [15:0]                            o_range_mm,
    output logic                                   o_range_valid
);

    // configuration
    logic signed [19:0] r_hlow, r_hhigh;
    logic [15:0]        r_rlow, r_rhigh;
    logic signed [15:0] r_astart;
    logic signed [16:0] r_aend;
    logic [15:0]        r_astep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hlow   <= -20'sd500;
            r_hhigh  <= 20'sd2000;
            r_rlow   <= 16'd100;
            r_rhigh  <= 16'd50000;
            r_astart <= -16'sd32768;
            r_aend   <= 17'sd32768;
            r_astep  <= 16'd182;
        end else if (i_cfg_we) begin
            case (pcsb_pkg::t_cfg_idx'(i_cfg_idx))
                pcsb_pkg::CFG_HEIGHT_LOW:  r_hlow   <= i_cfg_data;
                pcsb_pkg::CFG_HEIGHT_HIGH: r_hhigh  <= i_cfg_data;
                pcsb_pkg::CFG_RANGE_LOW:   r_rlow   <= i_cfg_data[15:0];
                pcsb_pkg::CFG_RANGE_HIGH:  r_rhigh  <= i_cfg_data[15:0];
                pcsb_pkg::CFG_ANGLE_START: r_astart <= i_cfg_data[15:0];
                pcsb_pkg::CFG_ANGLE_END:   r_aend   <= i_cfg_data[16:0];
                pcsb_pkg::CFG_ANGLE_STEP:  r_astep  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // captured point
    logic signed [19:0] r_x, r_y, r_z;
    logic [pcsb_pkg::BIN_SEL_W-1:0] r_sel;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_x   <= i_x_mm;
            r_y   <= i_y_mm;
            r_z   <= i_z_mm;
            r_sel <= i_bin_select;
        end
    end

    // shared multiplier: x^2, y^2, low^2, high^2 in turn
    logic signed [19:0] mul_a;
    logic signed [39:0] r_prod;
    logic [1:0]         r_psel;
    logic [39:0]        r_r2;
    logic [31:0]        r_lo2, r_hi2;

    always_comb begin
        case (i_dp_cmd.cnt[1:0])
            2'd0:    mul_a = r_x;
            2'd1:    mul_a = r_y;
            2'd2:    mul_a = {4'd0, r_rlow};
            default: mul_a = {4'd0, r_rhigh};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.mul_en) begin
            r_prod <= mul_a * mul_a;
            r_psel <= i_dp_cmd.cnt[1:0];
        end
        if (i_dp_cmd.acc_en) begin
            case (r_psel)
                2'd0:    r_r2  <= r_prod;
                2'd1:    r_r2  <= r_r2 + r_prod;
                2'd2:    r_lo2 <= r_prod[31:0];
                default: r_hi2 <= r_prod[31:0];
            endcase
        end
    end

    assign o_sts.height_ok = (r_z >= r_hlow) && (r_z <= r_hhigh);
    assign o_sts.range_ok  = (r_r2 >= {8'd0, r_lo2}) && (r_r2 <= {8'd0, r_hi2});

    // vectoring CORDIC, one step a cycle
    logic signed [39:0] r_cx, r_cy;
    logic signed [17:0] r_cz;
    logic signed [39:0] x_ext, y_ext, cdx, cdy;
    logic signed [17:0] c_at;

    assign x_ext = 40'(r_x);
    assign y_ext = 40'(r_y);
    assign cdx   = r_cy >>> i_dp_cmd.cnt;
    assign cdy   = r_cx >>> i_dp_cmd.cnt;
    assign c_at  = {4'd0, pcsb_pkg::atan_tab(i_dp_cmd.cnt[4:0])};

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.cordic_init) begin
            if (r_x < 0) begin
                r_cx <= (-x_ext) <<< 16;
                r_cy <= (-y_ext) <<< 16;
                r_cz <= 18'sd32768;
            end else begin
                r_cx <= x_ext <<< 16;
                r_cy <= y_ext <<< 16;
                r_cz <= '0;
            end
        end else if (i_dp_cmd.cordic_step) begin
            if (!r_cy[39]) begin
                r_cx <= r_cx + cdx;
                r_cy <= r_cy - cdy;
                r_cz <= r_cz + c_at;
            end else begin
                r_cx <= r_cx - cdx;
                r_cy <= r_cy + cdy;
                r_cz <= r_cz - c_at;
            end
        end
    end

    // wrap into the window and offset from start
    logic signed [18:0] ang, ang_w, off, start_s, end_s;
    logic signed [17:0] win_d;

    assign start_s = 19'(r_astart);
    assign end_s   = 19'(r_aend);
    assign ang     = ((r_x == '0) && (r_y == '0)) ? '0 : 19'($signed(r_cz[15:0]));
    always_comb begin
        if (ang < start_s)    ang_w = ang + 19'sd65536;
        else if (ang > end_s) ang_w = ang - 19'sd65536;
        else                  ang_w = ang;
    end
    assign off          = ang_w - start_s;
    assign o_sts.off_ok = !off[18];
    assign win_d        = 18'(r_aend) - 18'(r_astart);

    // restoring divider by angle_step, one quotient bit a cycle
    logic [15:0] step_eff, r_rem;
    logic [16:0] r_dvd, r_quo, r_qd, div_t;
    logic        div_ge;

    assign step_eff = (r_astep == '0) ? 16'd1 : r_astep;
    assign div_t    = {r_rem, r_dvd[16]};
    assign div_ge   = (div_t >= {1'b0, step_eff});

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.qd_save) r_qd <= r_quo;
        if (i_dp_cmd.div_init_d || i_dp_cmd.div_init_off) begin
            r_dvd <= i_dp_cmd.div_init_d ? win_d[16:0] : off[16:0];
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_dp_cmd.div_step) begin
            r_rem <= div_ge ? 16'(div_t - {1'b0, step_eff}) : div_t[15:0];
            r_dvd <= {r_dvd[15:0], 1'b0};
            r_quo <= {r_quo[15:0], div_ge};
        end
    end

    assign o_sts.idx_ok = !win_d[17] && (r_quo <= r_qd)
                          && (r_quo < 17'(pcsb_pkg::NUM_BINS));

    // digit-by-digit square root, two radicand bits a cycle
    logic [39:0] r_sv;
    logic [21:0] r_srem;
    logic [19:0] r_root;
    logic [23:0] sq_t, sq_trial;
    logic        sq_ge;

    assign sq_t     = {r_srem, r_sv[39:38]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.sqrt_init) begin
            r_sv   <= r_r2;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_dp_cmd.sqrt_step) begin
            r_sv   <= {r_sv[37:0], 2'b00};
            r_srem <= sq_ge ? 22'(sq_t - sq_trial) : sq_t[21:0];
            r_root <= {r_root[18:0], sq_ge};
        end
    end

    // bin store
    logic [pcsb_pkg::RANGE_W-1:0] mem [pcsb_pkg::NUM_BINS];
    logic [pcsb_pkg::RANGE_W-1:0] r_mem_q, wr_data;
    logic [pcsb_pkg::ADDR_W-1:0]  idx_addr, sel_addr, rd_addr, wr_addr;
    logic [12:0]                  sel_ext;
    logic                         sel_ok, wr_en;

    assign sel_ext  = 13'(r_sel);
    assign sel_ok   = (sel_ext < 13'(pcsb_pkg::NUM_BINS));
    assign sel_addr = sel_ext[pcsb_pkg::ADDR_W-1:0];
    assign idx_addr = r_quo[pcsb_pkg::ADDR_W-1:0];
    assign rd_addr  = i_dp_cmd.rd_bin ? sel_addr : idx_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_addr;
        wr_data = pcsb_pkg::EMPTY_RANGE;
        if (i_dp_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = i_dp_cmd.cnt[pcsb_pkg::ADDR_W-1:0];
        end else if (i_dp_cmd.out_en) begin
            wr_en   = sel_ok;
            wr_addr = sel_addr;
        end else if (i_dp_cmd.upd_wr) begin
            wr_en   = ({1'b0, r_root[15:0]} < r_mem_q);
            wr_data = {1'b0, r_root[15:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_dp_cmd.rd_en) r_mem_q <= mem[rd_addr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_dp_cmd.out_en;
        end
        if (i_dp_cmd.out_en) begin
            if (sel_ok && !r_mem_q[16]) begin
                o_range_mm    <= r_mem_q[15:0];
                o_range_valid <= 1'b1;
            end else begin
                o_range_mm    <= '0;
                o_range_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/point_cloud_to_scan_binner.sv */
// Top level of the point cloud to scan binner.
// Add point: busy after the transfer until the point is binned, next point taken once idle;
//   a dropped point ends early at the height/range, angle window or bin index check.
// Read bin: bin read, then result registered and strobed; the next item is taken in the strobe cycle.
// Reset (synchronous, active low) loads default config, then a clear sweep writes all
//   NUM_BINS (512) bins of the store with busy high; results cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module point_cloud_to_scan_binner (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcsb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pcsb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_cmd,
    input  wire logic signed [19:0]                i_x_mm,
    input  wire logic signed [19:0]                i_y_mm,
    input  wire logic signed [19:0]                i_z_mm,
    input  wire logic [pcsb_pkg::BIN_SEL_W-1:0]    i_bin_select,
    output logic                                   o_valid,
    output logic [15:0]                            o_range_mm,
    output logic                                   o_range_valid
);

    pcsb_pkg::t_dp_cmd dp_cmd;
    pcsb_pkg::t_dp_sts dp_sts;

    pcsb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_sts    (dp_sts),
        .o_dp_cmd (dp_cmd),
        .o_busy   (busy)
    );

    pcsb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_x_mm        (i_x_mm),
        .i_y_mm        (i_y_mm),
        .i_z_mm        (i_z_mm),
        .i_bin_select  (i_bin_select),
        .i_dp_cmd      (dp_cmd),
        .o_sts         (dp_sts),
        .o_valid       (o_valid),
        .o_range_mm    (o_range_mm),
        .o_range_valid (o_range_valid)
    );

    // a result only comes out of a read that kept the block busy
    `ASSERT_CLK(a_out_after_busy, i_clk, i_rst_n, o_valid |-> $past(busy))
    // an added point never gives a result in the next cycle
    `ASSERT_NEXT(a_add_no_out, i_clk, i_rst_n, start && !busy && !i_cmd, !o_valid)
    // the result strobe lasts one cycle
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)

endmodule
`default_nettype wire

/* bench/scan_bin_checker.sv */
// Checker for the scan binner: tracks config and bin store, predicts readouts, compares.
`timescale 1ns / 1ps
module scan_bin_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcsb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pcsb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic                              i_cmd,
    input  wire logic signed [19:0]                i_x_mm,
    input  wire logic signed [19:0]                i_y_mm,
    input  wire logic signed [19:0]                i_z_mm,
    input  wire logic [pcsb_pkg::BIN_SEL_W-1:0]    i_bin_select,
    input  wire logic                              o_valid,
    input  wire logic [15:0]                       o_range_mm,
    input  wire logic                              o_range_valid,
    output int                                     o_errors,
    output int                                     o_pending,
    output int                                     o_hits
);
    import pcsb_pkg::*;

    typedef struct {
        logic [15:0] range_mm;
        logic        range_valid;
    } t_readout;

    localparam longint ATAN_UNITS [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                           41, 20, 10, 5, 3, 1, 1, 0};

    longint         height_lo, height_hi, range_lo, range_hi;
    longint         ang_start, ang_end, ang_step;
    longint         usable_bins;
    logic [16:0]    nearest [NUM_BINS];
    t_readout       readout_q [$];

    function automatic longint sx(input logic [19:0] v, input int w);
        longint r;
        r = v & ((64'd1 << w) - 1);
        if (r >= (64'sd1 <<< (w - 1)))
            r = r - (64'sd1 <<< w);
        return r;
    endfunction

    function automatic longint recount(input longint st, input longint en, input longint sp);
        longint n;
        if (en < st)
            return 0;
        n = (en - st) / ((sp == 0) ? 1 : sp) + 1;
        return (n > NUM_BINS) ? NUM_BINS : n;
    endfunction

    function automatic longint binary_angle(input longint px, input longint py);
        longint x, y, z, dx, dy;
        x = px;
        y = py;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32768;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += ATAN_UNITS[i];
            end else begin
                x -= dx;
                y += dy;
                z -= ATAN_UNITS[i];
            end
        end
        return longint'(signed'(z[15:0]));
    endfunction

    function automatic longint isqrt_floor(input longint v);
        longint r, b, rem;
        r = 0;
        rem = v;
        b = 64'sd1 <<< 62;
        while (b > rem)
            b = b >>> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem -= r + b;
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    task automatic bin_point(input longint x, input longint y, input longint z);
        longint r2, a, off, idx, r;
        if (z < height_lo || z > height_hi)
            return;
        r2 = x * x + y * y;
        if (r2 < range_lo * range_lo || r2 > range_hi * range_hi)
            return;
        a = binary_angle(x, y);
        if (a < ang_start)
            a += 65536;
        else if (a > ang_end)
            a -= 65536;
        off = a - ang_start;
        if (off < 0)
            return;
        idx = off / ((ang_step == 0) ? 1 : ang_step);
        if (idx >= usable_bins || idx >= NUM_BINS)
            return;
        r = isqrt_floor(r2);
        if (r < nearest[idx]) begin
            nearest[idx] = r[16:0];
            o_hits++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_hits = 0;
    end

    always @(posedge i_clk) begin
        t_readout e, got;
        if (!i_rst_n) begin
            height_lo = -500;
            height_hi = 2000;
            range_lo = 100;
            range_hi = 50000;
            ang_start = -32768;
            ang_end = 32768;
            ang_step = 182;
            usable_bins = recount(ang_start, ang_end, ang_step);
            foreach (nearest[i])
                nearest[i] = EMPTY_RANGE;
            readout_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HEIGHT_LOW:  height_lo = sx(i_cfg_data, 20);
                    CFG_HEIGHT_HIGH: height_hi = sx(i_cfg_data, 20);
                    CFG_RANGE_LOW:   range_lo = i_cfg_data[15:0];
                    CFG_RANGE_HIGH:  range_hi = i_cfg_data[15:0];
                    CFG_ANGLE_START: ang_start = sx(i_cfg_data, 16);
                    CFG_ANGLE_END:   ang_end = sx(i_cfg_data, 17);
                    CFG_ANGLE_STEP:  ang_step = i_cfg_data[15:0];
                    default: ;
                endcase
                usable_bins = recount(ang_start, ang_end, ang_step);
            end
            // older readout is compared before a new read is queued
            if (o_valid) begin
                got.range_mm = o_range_mm;
                got.range_valid = o_range_valid;
                if (readout_q.size() == 0) begin
                    $display("%0t: unexpected readout, got range %0d valid %0b",
                             $time, got.range_mm, got.range_valid);
                    o_errors++;
                end else begin
                    e = readout_q.pop_front();
                    if (e.range_mm !== got.range_mm) begin
                        $display("%0t: range_mm expected %0d got %0d",
                                 $time, e.range_mm, got.range_mm);
                        o_errors++;
                    end
                    if (e.range_valid !== got.range_valid) begin
                        $display("%0t: range_valid expected %0b got %0b",
                                 $time, e.range_valid, got.range_valid);
                        o_errors++;
                    end
                end
            end
            if (start && !busy) begin
                if (i_cmd) begin
                    e.range_mm = 0;
                    e.range_valid = 0;
                    if (i_bin_select < NUM_BINS) begin
                        if (nearest[i_bin_select] < EMPTY_RANGE) begin
                            e.range_mm = nearest[i_bin_select][15:0];
                            e.range_valid = 1;
                        end
                        nearest[i_bin_select] = EMPTY_RANGE;
                    end
                    readout_q.push_back(e);
                end else begin
                    bin_point(i_x_mm, i_y_mm, i_z_mm);
                end
            end
        end
        o_pending = readout_q.size();
    end

    final begin
        if (readout_q.size() != 0)
            $display("%0t: %0d readouts never arrived", $time, readout_q.size());
    end
endmodule

/* bench/testbench.sv */
// Testbench top: stimulus, config phases and verdict for the scan binner.
`timescale 1ns / 1ps
module testbench;
    import pcsb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 60;
    localparam int PER_PHASE = 342;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   start;
    logic                   busy;
    logic                   i_cmd;
    logic signed [19:0]     i_x_mm, i_y_mm, i_z_mm;
    logic [BIN_SEL_W-1:0]   i_bin_select;
    logic                   o_valid;
    logic [15:0]            o_range_mm;
    logic                   o_range_valid;
    int                     n_errors, n_pending, n_hits;
    int                     cycles, n_adds, n_reads, burst_left;
    int                     lo_z, hi_z, max_r;

    point_cloud_to_scan_binner DUT (.*);

    scan_bin_checker u_checker (.*, .o_errors(n_errors), .o_pending(n_pending),
                                .o_hits(n_hits));

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // fields are held until the transfer; start stays high for back-to-back items
    task automatic put(input logic c, input int x, input int y, input int z, input int sel);
        start <= 1;
        i_cmd <= c;
        i_x_mm <= 20'(x);
        i_y_mm <= 20'(y);
        i_z_mm <= 20'(z);
        i_bin_select <= BIN_SEL_W'(sel);
        do @(posedge i_clk); while (busy);
        if (c == CMD_READ)
            n_reads++;
        else
            n_adds++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
            idle($urandom_range(1, 8));
        end
    endtask

    task automatic idle(input int n);
        start <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (n_pending != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // the enable is dropped after each write, which keeps the enable pulses apart
    task automatic wr_cfg(input logic [CFG_IDX_W-1:0] idx, input int v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic setup(input int hl, input int hh, input int rl, input int rh,
                         input int as, input int ae, input int st);
        drain();
        wr_cfg(CFG_HEIGHT_LOW, hl);
        wr_cfg(CFG_HEIGHT_HIGH, hh);
        wr_cfg(CFG_RANGE_LOW, rl);
        wr_cfg(CFG_RANGE_HIGH, rh);
        wr_cfg(CFG_ANGLE_START, as);
        wr_cfg(CFG_ANGLE_END, ae);
        wr_cfg(CFG_ANGLE_STEP, st);
        lo_z = hl;
        hi_z = hh;
        max_r = rh * 7 / 10 + 1;
    endtask

    function automatic int srand(input int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    task automatic random_items(input int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 25)
                put(CMD_READ, srand(524287), srand(524287), srand(524287),
                    kind < 12 ? $urandom_range(63) : $urandom_range(511));
            else if (kind < 88)
                put(CMD_ADD, srand(max_r), srand(max_r),
                    hi_z >= lo_z ? lo_z + int'($urandom_range(hi_z - lo_z)) : srand(3000),
                    $urandom_range(511));
            else
                put(CMD_ADD, $urandom, $urandom, $urandom, $urandom_range(511));
            if (i == n / 2 && $urandom_range(1) == 0)
                drain();
        end
    endtask

    initial begin
        cycles = 0;
        n_adds = 0;
        n_reads = 0;
        burst_left = 0;
        lo_z = -500;
        hi_z = 2000;
        max_r = 35000;
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        start <= 0;
        i_cmd <= 0;
        i_x_mm <= '0;
        i_y_mm <= '0;
        i_z_mm <= '0;
        i_bin_select <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: field extremes, window edges, height and range borders
        put(CMD_READ, 0, 0, 0, 180);
        put(CMD_ADD, 524287, 0, 0, 0);
        put(CMD_ADD, -524288, -524288, -524288, 0);
        put(CMD_ADD, 1000, 0, 0, 0);
        put(CMD_ADD, 1200, 1, -500, 0);
        put(CMD_ADD, 900, 0, -501, 0);
        put(CMD_ADD, -1000, 0, 2000, 0);
        put(CMD_ADD, -1000, 1, 2001, 0);
        put(CMD_ADD, 0, 1000, 0, 0);
        put(CMD_ADD, 0, -50000, 0, 0);
        put(CMD_ADD, 50000, 1, 0, 0);
        put(CMD_ADD, 60, 80, 0, 0);
        put(CMD_ADD, 60, 79, 0, 0);
        put(CMD_READ, 0, 0, 0, 180);
        put(CMD_READ, 0, 0, 0, 180);
        put(CMD_READ, 0, 0, 0, 360);
        put(CMD_READ, 0, 0, 0, 0);
        put(CMD_READ, 0, 0, 0, 270);
        put(CMD_READ, 0, 0, 0, 90);
        put(CMD_READ, 0, 0, 0, 511);
        setup(-500, 2000, 0, 50000, -32768, 32768, 182);
        wr_cfg(CFG_SPARE, 12345);
        put(CMD_ADD, 0, 0, 0, 0);
        put(CMD_READ, 0, 0, 0, 180);
        put(CMD_READ, 0, 0, 0, 180);
        setup(-500, 2000, 100, 50000, -32768, 32768, 182);
        random_items(PER_PHASE);
        setup(-524288, 524287, 0, 65535, -32768, 65535, 65535);
        random_items(PER_PHASE);
        setup(-100, 100, 50, 3000, -4000, 4000, 0);
        random_items(PER_PHASE);
        setup(0, 5000, 200, 20000, 1000, -1000, 100);
        random_items(60);
        setup(-2000, 1500, 10, 65535, -16384, 16383, 64);
        random_items(PER_PHASE);
        drain();

        $display("ran %0d point adds and %0d bin reads over six config settings",
                 n_adds, n_reads);
        $display("%0d points landed closer than the stored bin range", n_hits);
        if (n_errors == 0 && n_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
